// File: rtl/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg: shared types, codes and helpers for the maze carver
// Request and direction codes, the sequencer state type and the small
// neighbour-pick arithmetic used by the step sequence.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

    // default grid bounds
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 32;

    // width used for grid sizes and coordinate compares (values up to 511)
    localparam int DIM_W = 9;

    // configuration register indexes and reset values
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;
    localparam logic [6:0] RST_WIDTH  = 7'd36;
    localparam logic [5:0] RST_HEIGHT = 6'd25;

    // request codes
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_STEP  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // direction codes
    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SEED,
        S_PROBE,
        S_PICK,
        S_POP,
        S_RDWAIT,
        S_DONE
    } t_state;

    // count of open neighbours
    function automatic logic [2:0] count_free(input logic [3:0] free);
        logic [2:0] c;
        c = 3'd0;
        for (int k = 0; k < 4; k++) begin
            c = c + 3'(free[k]);
        end
        return c;
    endfunction

    // random value modulo a neighbour count of 1 to 4
    function automatic logic [1:0] mod_small(input logic [15:0] v, input logic [2:0] n);
        logic [4:0] s;
        logic [2:0] t;
        logic [1:0] r;
        s = 5'd0;
        // base-4 digits sum to the same residue mod 3
        for (int k = 0; k < 8; k++) begin
            s = s + 5'(v[2*k +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        case (n)
            3'd2:    r = {1'b0, v[0]};
            3'd3:    r = t[1:0];
            3'd4:    r = v[1:0];
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // direction of the sel-th open neighbour, north first
    function automatic logic [1:0] pick_dir(input logic [3:0] free, input logic [1:0] sel);
        logic [2:0] c;
        logic [1:0] d;
        c = 3'd0;
        d = DIR_N;
        for (int k = 0; k < 4; k++) begin
            if (free[k]) begin
                if (c == 3'(sel)) begin
                    d = 2'(k);
                end
                c = c + 3'd1;
            end
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// File: rtl/dmc_ram.sv
// ----------------------------------------------------------------------------
// dmc_ram: simple dual-port memory
// One write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_ram #(
    parameter int WIDTH = 1,
    parameter int AW    = 11
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [2**AW];

    // write, then registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/dmc_probe.sv
// ----------------------------------------------------------------------------
// dmc_probe: neighbour unit
// Gives the neighbour of a cell in one direction and whether it lies in the
// grid in use. Shared by every probe and by the carve.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_probe
    import dmc_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int COL_W    = $clog2(MAX_COLS),
    parameter int ROW_W    = $clog2(MAX_ROWS)
) (
    input  wire logic [COL_W-1:0] i_x,
    input  wire logic [ROW_W-1:0] i_y,
    input  wire logic [1:0]       i_dir,
    input  wire logic [DIM_W-1:0] i_w,
    input  wire logic [DIM_W-1:0] i_h,
    output logic                  o_inb,
    output logic      [COL_W-1:0] o_nx,
    output logic      [ROW_W-1:0] o_ny
);

    logic [DIM_W-1:0] xe;
    logic [DIM_W-1:0] ye;

    assign xe = DIM_W'(i_x) + DIM_W'(1);
    assign ye = DIM_W'(i_y) + DIM_W'(1);

    // neighbour coordinates and grid test
    always_comb begin
        o_nx  = i_x;
        o_ny  = i_y;
        o_inb = 1'b0;
        unique case (i_dir)
            DIR_N: begin
                o_inb = (i_y != '0);
                o_ny  = i_y - ROW_W'(1);
            end
            DIR_E: begin
                o_inb = (xe < i_w) && (xe < DIM_W'(MAX_COLS));
                o_nx  = i_x + COL_W'(1);
            end
            DIR_S: begin
                o_inb = (ye < i_h) && (ye < DIM_W'(MAX_ROWS));
                o_ny  = i_y + ROW_W'(1);
            end
            DIR_W: begin
                o_inb = (i_x != '0);
                o_nx  = i_x - COL_W'(1);
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/dfs_maze_carver.sv
// ----------------------------------------------------------------------------
// dfs_maze_carver: depth-first maze generator
// Builds a perfect maze by randomised depth-first search with a cell stack.
//
// Input stream: tuser carries the request (start, step, read); tdata carries
// the random value and a cell column and row. Output stream: one result
// transaction per request with carve flag and direction, top-of-stack cell,
// finished flag and the read passage bits. Configuration: write enable,
// register index (0 width, 1 height) and data, taken on any cycle.
// The block takes one request at a time and drops ready while it works.
// Step: accept, a probe of each direction through the shared neighbour unit
// over the visited-map read port, a pick, a stack read after a pop, and the
// output load. Read: accept, map read, output load. Start: a clearing sweep
// over all 2**AW map entries (2048 by default), seed and output load. After
// reset the same clearing sweep runs before the first request is taken; the
// stack is empty so a step reports finished. A finished result waits in the
// output register while the next request is accepted; when the receiver
// stalls, the block holds its next result until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_maze_carver
    import dmc_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [6:0]  i_cfg_wdata,
    // request stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,  // rand_value, cell_x, cell_y, zero pad
    input  wire logic [1:0]  i_s_tuser,  // req_type
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [23:0] o_m_tdata   // carved, carve_dir, new_x, new_y,
                                         // finished, east_open, south_open, pad
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int AW    = COL_W + ROW_W;
    localparam int DEPTH = 2**AW;

    t_state r_state, n_state;

    logic [6:0]       r_width;
    logic [5:0]       r_height;
    logic [AW-1:0]    r_clr;
    logic             r_seed;
    logic [COL_W-1:0] r_start_x;
    logic [ROW_W-1:0] r_start_y;
    logic [COL_W-1:0] r_top_x;
    logic [ROW_W-1:0] r_top_y;
    logic [AW:0]      r_depth;
    logic [15:0]      r_rnd;
    logic [2:0]       r_dir;
    logic             r_inb;
    logic [3:0]       r_free;
    logic             r_carved;
    logic [1:0]       r_cdir;
    logic             r_rd_ok;
    logic             r_east;
    logic             r_south;
    logic             r_o_valid;
    logic [23:0]      r_o_data;

    logic [DIM_W-1:0] w_use, h_use, w_last, h_last;
    logic [15:0]      in_rnd;
    logic [5:0]       in_x;
    logic [4:0]       in_y;
    logic             accept;
    logic             out_load;
    logic [2:0]       free_cnt;
    logic [1:0]       pick_d;
    logic [1:0]       probe_dir;
    logic             probe_inb;
    logic [COL_W-1:0] nx;
    logic [ROW_W-1:0] ny;
    logic [AW-1:0]    top_addr, nb_addr, map_raddr, in_addr;
    logic [AW:0]      depth_m2;
    logic             can_push;
    logic [DIM_W-1:0] sx_full, sy_full;

    logic             vis_we, east_we, south_we, stk_we;
    logic [AW-1:0]    vis_wa, east_wa, south_wa, stk_wa, stk_ra;
    logic             vis_wd, east_wd, south_wd;
    logic [AW-1:0]    stk_wd;
    logic             vis_rd, east_rd, south_rd;
    logic [AW-1:0]    stk_rd;

    assign in_rnd = i_s_tdata[15:0];
    assign in_x   = i_s_tdata[21:16];
    assign in_y   = i_s_tdata[26:22];

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_load   = (r_state == S_DONE) && (!r_o_valid || i_m_tready);
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

    // saturate the grid size into the parameter range
    always_comb begin
        if (DIM_W'(r_width) < DIM_W'(2)) begin
            w_use = DIM_W'(2);
        end else if (DIM_W'(r_width) > DIM_W'(MAX_COLS)) begin
            w_use = DIM_W'(MAX_COLS);
        end else begin
            w_use = DIM_W'(r_width);
        end
        if (DIM_W'(r_height) < DIM_W'(2)) begin
            h_use = DIM_W'(2);
        end else if (DIM_W'(r_height) > DIM_W'(MAX_ROWS)) begin
            h_use = DIM_W'(MAX_ROWS);
        end else begin
            h_use = DIM_W'(r_height);
        end
    end

    assign w_last  = w_use - DIM_W'(1);
    assign h_last  = h_use - DIM_W'(1);
    assign sx_full = (DIM_W'(in_x) > w_last) ? w_last : DIM_W'(in_x);
    assign sy_full = (DIM_W'(in_y) > h_last) ? h_last : DIM_W'(in_y);

    assign free_cnt = count_free(r_free);
    assign pick_d   = pick_dir(r_free, mod_small(r_rnd, free_cnt));
    assign top_addr = {r_top_y, r_top_x};
    assign nb_addr  = {ny, nx};
    assign in_addr  = {ROW_W'(in_y), COL_W'(in_x)};
    assign depth_m2 = r_depth - (AW+1)'(2);
    assign can_push = (r_depth != (AW+1)'(DEPTH));

    // shared neighbour unit: probe direction in the scan, chosen one on carve
    assign probe_dir = (r_state == S_PICK) ? pick_d : r_dir[1:0];

    dmc_probe #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .COL_W    (COL_W),
        .ROW_W    (ROW_W)
    ) u_probe (
        .i_x   (r_top_x),
        .i_y   (r_top_y),
        .i_dir (probe_dir),
        .i_w   (w_use),
        .i_h   (h_use),
        .o_inb (probe_inb),
        .o_nx  (nx),
        .o_ny  (ny)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = r_seed ? S_SEED : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_s_tuser)
                        REQ_START: n_state = S_CLEAR;
                        REQ_STEP:  n_state = (r_depth == '0) ? S_DONE : S_PROBE;
                        REQ_READ:  n_state = S_RDWAIT;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_SEED:   n_state = S_DONE;
            S_PROBE:  n_state = (r_dir == 3'd4) ? S_PICK : S_PROBE;
            S_PICK: begin
                if (free_cnt == 3'd0 && r_depth > (AW+1)'(1)) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_POP:    n_state = S_DONE;
            S_RDWAIT: n_state = S_DONE;
            S_DONE:   n_state = out_load ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    // memory port controls
    always_comb begin
        vis_we   = 1'b0;
        vis_wa   = r_clr;
        vis_wd   = 1'b0;
        east_we  = 1'b0;
        east_wa  = r_clr;
        east_wd  = 1'b0;
        south_we = 1'b0;
        south_wa = r_clr;
        south_wd = 1'b0;
        stk_we   = 1'b0;
        stk_wa   = r_depth[AW-1:0];
        stk_wd   = nb_addr;
        stk_ra   = depth_m2[AW-1:0];
        map_raddr = top_addr;
        unique case (r_state)
            S_CLEAR: begin
                vis_we   = 1'b1;
                east_we  = 1'b1;
                south_we = 1'b1;
            end
            S_IDLE: begin
                map_raddr = in_addr;
            end
            S_SEED: begin
                vis_we = 1'b1;
                vis_wa = {r_start_y, r_start_x};
                vis_wd = 1'b1;
                stk_we = 1'b1;
                stk_wa = '0;
                stk_wd = {r_start_y, r_start_x};
            end
            S_PROBE: begin
                map_raddr = nb_addr;
            end
            S_PICK: begin
                if (free_cnt != 3'd0) begin
                    vis_we = 1'b1;
                    vis_wa = nb_addr;
                    vis_wd = 1'b1;
                    stk_we = can_push;
                    case (pick_d)
                        DIR_N: begin
                            south_we = 1'b1;
                            south_wa = nb_addr;
                            south_wd = 1'b1;
                        end
                        DIR_E: begin
                            east_we = 1'b1;
                            east_wa = top_addr;
                            east_wd = 1'b1;
                        end
                        DIR_S: begin
                            south_we = 1'b1;
                            south_wa = top_addr;
                            south_wd = 1'b1;
                        end
                        default: begin
                            east_we = 1'b1;
                            east_wa = nb_addr;
                            east_wd = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                map_raddr = top_addr;
            end
        endcase
    end

    dmc_ram #(.WIDTH(1), .AW(AW)) u_visited (
        .i_clk (i_clk), .i_we (vis_we), .i_waddr (vis_wa), .i_wdata (vis_wd),
        .i_raddr (map_raddr), .o_rdata (vis_rd)
    );

    dmc_ram #(.WIDTH(1), .AW(AW)) u_east (
        .i_clk (i_clk), .i_we (east_we), .i_waddr (east_wa), .i_wdata (east_wd),
        .i_raddr (map_raddr), .o_rdata (east_rd)
    );

    dmc_ram #(.WIDTH(1), .AW(AW)) u_south (
        .i_clk (i_clk), .i_we (south_we), .i_waddr (south_wa), .i_wdata (south_wd),
        .i_raddr (map_raddr), .o_rdata (south_rd)
    );

    dmc_ram #(.WIDTH(AW), .AW(AW)) u_stack (
        .i_clk (i_clk), .i_we (stk_we), .i_waddr (stk_wa), .i_wdata (stk_wd),
        .i_raddr (stk_ra), .o_rdata (stk_rd)
    );

    // state register and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIDTH:  r_width  <= i_cfg_wdata;
                    default:    r_height <= i_cfg_wdata[5:0];
                endcase
            end
        end
    end

    // sequencer control: sweep counter, stack depth, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_seed    <= 1'b0;
            r_depth   <= '0;
            r_dir     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (accept) begin
                r_dir <= '0;
                if (i_s_tuser == REQ_START) begin
                    r_clr  <= '0;
                    r_seed <= 1'b1;
                end
            end
            if (r_state == S_PROBE) begin
                r_dir <= r_dir + 3'd1;
            end
            if (r_state == S_SEED) begin
                r_depth <= (AW+1)'(1);
            end
            if (r_state == S_PICK) begin
                if (free_cnt == 3'd0) begin
                    r_depth <= r_depth - (AW+1)'(1);
                end else if (can_push) begin
                    r_depth <= r_depth + (AW+1)'(1);
                end
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rnd     <= in_rnd;
            r_start_x <= COL_W'(sx_full);
            r_start_y <= ROW_W'(sy_full);
            r_free    <= '0;
            r_carved  <= 1'b0;
            r_cdir    <= DIR_N;
            r_east    <= 1'b0;
            r_south   <= 1'b0;
            r_rd_ok   <= (i_s_tuser == REQ_READ)
                         && (DIM_W'(in_x) < DIM_W'(MAX_COLS))
                         && (DIM_W'(in_y) < DIM_W'(MAX_ROWS));
        end
        if (r_state == S_SEED) begin
            r_top_x <= r_start_x;
            r_top_y <= r_start_y;
        end
        // capture one probe result per cycle, one behind the address
        if (r_state == S_PROBE) begin
            r_inb <= probe_inb;
            if (r_dir != 3'd0) begin
                r_free[r_dir[1:0] - 2'd1] <= r_inb & ~vis_rd;
            end
        end
        if (r_state == S_PICK && free_cnt != 3'd0) begin
            r_carved <= 1'b1;
            r_cdir   <= pick_d;
            r_top_x  <= nx;
            r_top_y  <= ny;
        end
        if (r_state == S_POP) begin
            r_top_x <= stk_rd[COL_W-1:0];
            r_top_y <= stk_rd[AW-1:COL_W];
        end
        if (r_state == S_RDWAIT) begin
            r_east  <= east_rd & r_rd_ok;
            r_south <= south_rd & r_rd_ok;
        end
        if (out_load) begin
            r_o_data <= {7'd0, r_south, r_east, (r_depth == '0),
                         (r_depth == '0) ? 5'd0 : 5'(r_top_y),
                         (r_depth == '0) ? 6'd0 : 6'(r_top_x),
                         r_cdir, r_carved};
        end
    end

    // stack never grows past the cell count
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= (AW+1)'(DEPTH))
        else $error("stack depth beyond cell count");

    // a carve leaves the stack non-empty
    a_carve_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> !o_m_tdata[14])
        else $error("carved result reports finished");

    // the probe scan ends only in the pick cycle
    a_probe_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |=> (r_state == S_PROBE || r_state == S_PICK))
        else $error("probe scan left early");

    // no request taken during the clearing sweep
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_tready)
        else $error("ready during clearing sweep");

endmodule

`default_nettype wire

// File: sim/dfs_maze_carver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dfs_maze_carver_tb: self-checking bench for the depth-first maze carver
// Drives start, step, read and unused requests over the request stream with
// random gaps, stalls the result stream at random and checks every result
// field against a local copy of the carving search. A short directed table
// comes first, then random mazes over a range of grid sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_maze_carver_tb
    import dmc_pkg::*;
;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int COLS = 64;
    localparam int ROWS = 32;
    localparam int NCELL = COLS * ROWS;
    localparam int TARGET_ITEMS = 1750;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [23:0] RES_FINISHED = 24'h004000;

    // result fields, carved in bit 0
    typedef struct packed {
        logic [6:0] pad;
        logic       south_open;
        logic       east_open;
        logic       finished;
        logic [4:0] new_y;
        logic [5:0] new_x;
        logic [1:0] carve_dir;
        logic       carved;
    } t_carve_res;

    typedef struct packed {
        logic [1:0]  req;
        logic [15:0] rnd;
        logic [5:0]  x;
        logic [4:0]  y;
        logic        lit;
        logic [23:0] res;
    } t_dir_row;

    localparam int NDIR = 17;
    localparam t_dir_row DIRECTED [NDIR] = '{
        '{REQ_STEP,  16'h0000, 6'd0,  5'd0,  1'b1, RES_FINISHED},
        '{REQ_NONE,  16'hFFFF, 6'd63, 5'd31, 1'b1, RES_FINISHED},
        '{REQ_READ,  16'h0000, 6'd0,  5'd0,  1'b1, RES_FINISHED},
        '{REQ_START, 16'h0000, 6'd63, 5'd31, 1'b1, 24'h003118},
        '{REQ_STEP,  16'h0000, 6'd0,  5'd0,  1'b0, 24'h0},
        '{REQ_STEP,  16'hFFFF, 6'd0,  5'd0,  1'b0, 24'h0},
        '{REQ_STEP,  16'h5555, 6'd0,  5'd0,  1'b0, 24'h0},
        '{REQ_STEP,  16'hAAAA, 6'd0,  5'd0,  1'b0, 24'h0},
        '{REQ_READ,  16'h0000, 6'd35, 5'd23, 1'b0, 24'h0},
        '{REQ_READ,  16'h0000, 6'd34, 5'd24, 1'b0, 24'h0},
        '{REQ_NONE,  16'h1234, 6'd10, 5'd10, 1'b0, 24'h0},
        '{REQ_START, 16'h0000, 6'd0,  5'd0,  1'b1, 24'h000000},
        '{REQ_STEP,  16'h0001, 6'd0,  5'd0,  1'b0, 24'h0},
        '{REQ_STEP,  16'h0002, 6'd0,  5'd0,  1'b0, 24'h0},
        '{REQ_STEP,  16'h0003, 6'd0,  5'd0,  1'b0, 24'h0},
        '{REQ_READ,  16'h0000, 6'd0,  5'd0,  1'b0, 24'h0},
        '{REQ_READ,  16'h0000, 6'd63, 5'd31, 1'b0, 24'h0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [6:0]  i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;   // rand_value, cell_x, cell_y, zero pad
    logic [1:0]  i_s_tuser;   // req_type
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;   // carved, carve_dir, new_x, new_y, finished,
                              // east_open, south_open, pad

    dfs_maze_carver i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // maze state mirror
    logic [6:0]  maze_w;
    logic [5:0]  maze_h;
    bit          visited   [NCELL];
    bit          east_pass [NCELL];
    bit          south_pass[NCELL];
    int          cell_stk  [NCELL];
    int          stk_depth;

    t_carve_res  pending_res[$];
    int          n_errors;
    int          n_sent;
    bit          src_steady;
    bit          snk_steady;

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // work out one result and advance the maze mirror
    function automatic t_carve_res carve_predict(logic [1:0] req, logic [15:0] rnd,
                                                 logic [5:0] x, logic [4:0] y);
        t_carve_res r;
        int w, h, cx, cy, c, nc, n, d;
        int dirs [4];
        r = '0;
        w = (maze_w < 2) ? 2 : ((maze_w > COLS) ? COLS : int'(maze_w));
        h = (maze_h < 2) ? 2 : ((maze_h > ROWS) ? ROWS : int'(maze_h));
        if (req == REQ_START) begin
            cx = (x > w - 1) ? w - 1 : int'(x);
            cy = (y > h - 1) ? h - 1 : int'(y);
            for (int i = 0; i < NCELL; i++) begin
                visited[i] = 0;
                east_pass[i] = 0;
                south_pass[i] = 0;
            end
            c = cy * COLS + cx;
            visited[c] = 1;
            cell_stk[0] = c;
            stk_depth = 1;
        end else if (req == REQ_STEP) begin
            if (stk_depth > 0) begin
                c = cell_stk[stk_depth - 1];
                cx = c % COLS;
                cy = c / COLS;
                n = 0;
                if (cy > 0 && !visited[c - COLS]) begin
                    dirs[n] = DIR_N;
                    n++;
                end
                if (cx + 1 < w && !visited[c + 1]) begin
                    dirs[n] = DIR_E;
                    n++;
                end
                if (cy + 1 < h && !visited[c + COLS]) begin
                    dirs[n] = DIR_S;
                    n++;
                end
                if (cx > 0 && !visited[c - 1]) begin
                    dirs[n] = DIR_W;
                    n++;
                end
                if (n == 0) begin
                    stk_depth--;
                end else begin
                    d = dirs[int'(rnd) % n];
                    case (2'(d))
                        DIR_N: begin
                            nc = c - COLS;
                            south_pass[nc] = 1;
                        end
                        DIR_E: begin
                            nc = c + 1;
                            east_pass[c] = 1;
                        end
                        DIR_S: begin
                            nc = c + COLS;
                            south_pass[c] = 1;
                        end
                        default: begin
                            nc = c - 1;
                            east_pass[nc] = 1;
                        end
                    endcase
                    visited[nc] = 1;
                    cell_stk[stk_depth] = nc;
                    stk_depth++;
                    r.carved = 1'b1;
                    r.carve_dir = 2'(d);
                end
            end
        end else if (req == REQ_READ) begin
            r.east_open = east_pass[int'(y) * COLS + int'(x)];
            r.south_open = south_pass[int'(y) * COLS + int'(x)];
        end
        if (stk_depth > 0) begin
            r.new_x = 6'(cell_stk[stk_depth - 1] % COLS);
            r.new_y = 5'(cell_stk[stk_depth - 1] / COLS);
        end else begin
            r.finished = 1'b1;
        end
        return r;
    endfunction

    // present one request, wait for the transaction, then idle for a random gap, possibly none
    task automatic send_req(logic [1:0] req, logic [15:0] rnd, logic [5:0] x,
                            logic [4:0] y, bit lit, logic [23:0] lit_res);
        t_carve_res r;
        int g, gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= {5'd0, y, x, rnd};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        r = carve_predict(req, rnd, x, y);
        pending_res.push_back(lit ? t_carve_res'(lit_res) : r);
        n_sent++;
        g = $urandom_range(0, 99);
        gap = src_steady ? 0 : (g < 55) ? 0 : (g < 90) ? $urandom_range(1, 3)
                                                       : $urandom_range(10, 60);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait for every result, then let the block settle
    task automatic drain;
        i_s_tvalid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic idx, logic [6:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_WIDTH) maze_w = val;
        else maze_h = val[5:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // result checking and random back-pressure
    always @(posedge i_clk) begin
        t_carve_res got, want;
        int g;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (pending_res.size() == 0) begin
                $error("result with nothing expected: %h", o_m_tdata);
                n_errors++;
            end else begin
                want = pending_res.pop_front();
                if (got.carved !== want.carved) begin
                    $error("carved: expected %0d got %0d", want.carved, got.carved);
                    n_errors++;
                end
                if (got.carve_dir !== want.carve_dir) begin
                    $error("carve_dir: expected %0d got %0d", want.carve_dir, got.carve_dir);
                    n_errors++;
                end
                if (got.new_x !== want.new_x) begin
                    $error("new_x: expected %0d got %0d", want.new_x, got.new_x);
                    n_errors++;
                end
                if (got.new_y !== want.new_y) begin
                    $error("new_y: expected %0d got %0d", want.new_y, got.new_y);
                    n_errors++;
                end
                if (got.finished !== want.finished) begin
                    $error("finished: expected %0d got %0d", want.finished, got.finished);
                    n_errors++;
                end
                if (got.east_open !== want.east_open) begin
                    $error("east_open: expected %0d got %0d", want.east_open, got.east_open);
                    n_errors++;
                end
                if (got.south_open !== want.south_open) begin
                    $error("south_open: expected %0d got %0d", want.south_open,
                           got.south_open);
                    n_errors++;
                end
            end
        end
        g = $urandom_range(0, 99);
        i_m_tready <= snk_steady ? 1'b1 : (g < 70) ? 1'b1 : (g < 95) ? 1'b0
                                                  : ($urandom_range(0, 3) == 0);
    end

    // watchdog on cycles without any transaction
    int idle_cycles;
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we
            || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        int phase, budget, cnt, g, wv, hv, cells;
        bit last_step;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_WIDTH;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = REQ_START;
        n_errors    = 0;
        n_sent      = 0;
        src_steady  = 0;
        snk_steady  = 0;
        maze_w      = RST_WIDTH;
        maze_h      = RST_HEIGHT;
        stk_depth   = 0;
        for (int i = 0; i < NCELL; i++) begin
            visited[i] = 0;
            east_pass[i] = 0;
            south_pass[i] = 0;
            cell_stk[i] = 0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at the reset size
        for (int i = 0; i < NDIR; i++) begin
            send_req(DIRECTED[i].req, DIRECTED[i].rnd, DIRECTED[i].x, DIRECTED[i].y,
                     DIRECTED[i].lit, DIRECTED[i].res);
        end

        // random mazes, one grid size per phase
        phase = 0;
        while (n_sent < TARGET_ITEMS) begin
            drain();
            case (phase)
                0: begin wv = 0;   hv = 0;  end
                1: begin wv = 127; hv = 63; end
                2: begin wv = 2;   hv = 2;  end
                3: begin wv = 64;  hv = 32; end
                4: begin wv = 2;   hv = 32; end
                5: begin wv = 64;  hv = 2;  end
                default: begin
                    wv = $urandom_range(2, 9);
                    hv = $urandom_range(2, 7);
                end
            endcase
            cfg_write(CFG_WIDTH, 7'(wv));
            cfg_write(CFG_HEIGHT, 7'(hv));
            src_steady = ($urandom_range(0, 4) == 0);
            snk_steady = ($urandom_range(0, 4) == 0);
            wv = (wv < 2) ? 2 : (wv > COLS) ? COLS : wv;
            hv = (hv < 2) ? 2 : (hv > ROWS) ? ROWS : hv;
            cells = wv * hv;
            budget = (2 * cells + 12 > 250) ? 250 : 2 * cells + 12;
            // sometimes carry on with the maze left from the last size
            last_step = ($urandom_range(0, 1) == 0) || (stk_depth == 0);
            cnt = 0;
            while (cnt < budget) begin
                g = $urandom_range(0, 99);
                if (stk_depth == 0 && last_step) begin
                    send_req(REQ_START, 16'($urandom), 6'($urandom), 5'($urandom), 0, '0);
                    last_step = 0;
                end else if (g < 84) begin
                    send_req(REQ_STEP, 16'($urandom), 6'($urandom), 5'($urandom), 0, '0);
                    last_step = 1;
                end else if (g < 93) begin
                    send_req(REQ_READ, 16'($urandom), 6'($urandom_range(0, wv)),
                             5'($urandom_range(0, hv)), 0, '0);
                end else if (g < 97) begin
                    send_req(REQ_NONE, 16'($urandom), 6'($urandom), 5'($urandom), 0, '0);
                end else begin
                    send_req(REQ_START, 16'($urandom), 6'($urandom), 5'($urandom), 0, '0);
                end
                cnt++;
            end
            phase++;
        end

        drain();
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
